[rtl/assert_macros.svh]
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression that must never be true outside reset
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

[rtl/dfsr_pkg.sv]
`timescale 1ns / 1ps

package dfsr_pkg;

    localparam int RADICAND_BITS         = 31;
    localparam int ROOT_BITS             = 26;
    localparam int MAX_FRACTION_DIGITS   = 3;
    localparam int FRAC_BITS             = 2;
    localparam int FRACTION_DIGITS_RESET = 3;

    // internal digit count, wide enough for the clamp value
    localparam int DIGIT_BITS = (MAX_FRACTION_DIGITS < 2) ? 1 : $clog2(MAX_FRACTION_DIGITS + 1);

    // each factor of 100 adds at most 7 bits
    localparam int SCALED_BITS   = RADICAND_BITS + 7 * MAX_FRACTION_DIGITS;
    localparam int SQ_BITS       = SCALED_BITS + (SCALED_BITS % 2);
    localparam int ITERS         = SQ_BITS / 2;
    localparam int REM_BITS      = ITERS + 2;
    localparam int ITER_CNT_BITS = (ITERS < 2) ? 1 : $clog2(ITERS);
    localparam logic [ITER_CNT_BITS-1:0] LAST_ITER = ITER_CNT_BITS'(ITERS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCALE = 4'b0010,
        ST_ROOT  = 4'b0100,
        ST_DONE  = 4'b1000
    } dfsr_state_t;

    typedef struct packed {
        logic load;
        logic scale_en;
        logic root_en;
        logic out_load;
    } dfsr_ctrl_t;

endpackage

[rtl/dfsr_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfsr_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [dfsr_pkg::DIGIT_BITS-1:0] digits,
    input  logic                           out_free,
    output logic                           idle,
    output dfsr_pkg::dfsr_ctrl_t           ctrl
);
    import dfsr_pkg::*;

    dfsr_state_t              state_reg, state_next;
    logic [DIGIT_BITS-1:0]    scale_cnt_reg, scale_cnt_next;
    logic [ITER_CNT_BITS-1:0] iter_cnt_reg, iter_cnt_next;

    always_comb
    begin
        state_next     = state_reg;
        scale_cnt_next = scale_cnt_reg;
        iter_cnt_next  = iter_cnt_reg;
        ctrl           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load      = 1'b1;
                    scale_cnt_next = '0;
                    iter_cnt_next  = '0;
                    state_next     = (digits == '0) ? ST_ROOT : ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                ctrl.scale_en  = 1'b1;
                scale_cnt_next = scale_cnt_reg + 1'b1;
                if (scale_cnt_reg == digits - 1'b1)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                ctrl.root_en  = 1'b1;
                iter_cnt_next = iter_cnt_reg + 1'b1;
                if (iter_cnt_reg == LAST_ITER)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scale_cnt_reg <= '0;
            iter_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scale_cnt_reg <= scale_cnt_next;
            iter_cnt_reg  <= iter_cnt_next;
        end
    end

    assign idle = (state_reg == ST_IDLE);

    // scaling never runs past the configured digit count
    `ASSERT_CLK(a_scale_bound, (state_reg == ST_SCALE) |-> (scale_cnt_reg < digits))
    // the last root step hands over to the result stage
    `ASSERT_CLK(a_root_done, (state_reg == ST_ROOT && iter_cnt_reg == LAST_ITER) |=> (state_reg == ST_DONE))

endmodule

[rtl/dfsr_datapath.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfsr_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dfsr_pkg::dfsr_ctrl_t              ctrl,
    input  logic [dfsr_pkg::RADICAND_BITS-1:0] radicand,
    output logic [dfsr_pkg::ITERS-1:0]        root
);
    import dfsr_pkg::*;

    logic [SQ_BITS-1:0]  work_reg, work_next;
    logic [REM_BITS-1:0] rem_reg, rem_next;
    logic [ITERS-1:0]    root_reg, root_next;

    logic [SQ_BITS-1:0]  times_100;
    logic [REM_BITS-1:0] rem_ext;
    logic [REM_BITS-1:0] trial_sub;
    logic [REM_BITS:0]   diff;

    // x * 100 = x*64 + x*32 + x*4
    assign times_100 = (work_reg << 6) + (work_reg << 5) + (work_reg << 2);

    // bring down the next pair of radicand bits and try root*4 + 1
    assign rem_ext   = {rem_reg[REM_BITS-3:0], work_reg[SQ_BITS-1 -: 2]};
    assign trial_sub = REM_BITS'({root_reg, 2'b01});
    assign diff      = {1'b0, rem_ext} - {1'b0, trial_sub};

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (ctrl.load)
        begin
            work_next = SQ_BITS'(radicand);
            rem_next  = '0;
            root_next = '0;
        end
        else if (ctrl.scale_en)
        begin
            work_next = times_100;
        end
        else if (ctrl.root_en)
        begin
            work_next = work_reg << 2;
            if (!diff[REM_BITS])
            begin
                rem_next  = diff[REM_BITS-1:0];
                root_next = {root_reg[ITERS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_ext;
                root_next = {root_reg[ITERS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign root = root_reg;

    // partial remainder never exceeds twice the partial root
    `ASSERT_CLK(a_rem_bound, rem_reg <= (REM_BITS'(root_reg) << 1))

endmodule

[rtl/decimal_fixed_point_square_root.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Decimal fixed-point square root: each radicand transfer gives one result,
// floor(sqrt(radicand) * 10^p), where p is the fraction_digits register
// (reset value 3, written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this).
// The block handles one item at a time. After a radicand transfer it scales
// by 100 p times (one shift-add per digit), then computes the root in the
// shared subtract-and-compare unit, one root bit per cycle, then moves the
// root into the output register once that register is free. The next
// radicand is taken only after that hand-over: the output register frees
// the input side as soon as the root is handed over, so a new radicand is
// taken while the previous result still waits on out_ready.
module decimal_fixed_point_square_root (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dfsr_pkg::FRAC_BITS-1:0]     cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [dfsr_pkg::RADICAND_BITS-1:0] radicand,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [dfsr_pkg::ROOT_BITS-1:0]     root_scaled
);
    import dfsr_pkg::*;

    logic [FRAC_BITS-1:0]  digits_reg;
    logic [DIGIT_BITS-1:0] eff_digits;
    logic                  out_valid_reg, out_valid_next;
    logic [ROOT_BITS-1:0]  root_scaled_reg;
    logic                  out_free;
    logic                  idle;
    logic [ITERS-1:0]      root;
    dfsr_ctrl_t            ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg <= FRAC_BITS'(FRACTION_DIGITS_RESET);
        end
        else if (cfg_we)
        begin
            digits_reg <= cfg_wdata;
        end
    end

    assign eff_digits = (int'(digits_reg) > MAX_FRACTION_DIGITS) ?
                        DIGIT_BITS'(MAX_FRACTION_DIGITS) : DIGIT_BITS'(digits_reg);

    assign out_free = !out_valid_reg || out_ready;

    dfsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .digits   (eff_digits),
        .out_free (out_free),
        .idle     (idle),
        .ctrl     (ctrl)
    );

    dfsr_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .radicand (radicand),
        .root     (root)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            root_scaled_reg <= ROOT_BITS'(root);
        end
    end

    assign in_ready    = idle;
    assign out_valid   = out_valid_reg;
    assign root_scaled = root_scaled_reg;

    // a finished root never overwrites a result still waiting for transfer
    `ASSERT_NEVER(a_no_overwrite, ctrl.out_load && out_valid_reg && !out_ready)

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import dfsr_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 64;
    localparam logic [RADICAND_BITS-1:0] RADICAND_MAX = '1;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_we      = 1'b0;
    logic [FRAC_BITS-1:0]     cfg_wdata   = '0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic [RADICAND_BITS-1:0] radicand    = '0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic [ROOT_BITS-1:0]     root_scaled;

    logic [RADICAND_BITS-1:0] pending_radicands[$];
    logic [ROOT_BITS-1:0]     expected_roots[$];

    logic [FRAC_BITS-1:0] digits_cfg = FRAC_BITS'(FRACTION_DIGITS_RESET);
    int unsigned idle_pct      = 0;
    int unsigned stall_pct     = 0;
    bit          long_hold_req = 1'b0;
    int          hold_left     = 0;
    int          error_cnt     = 0;
    int          items_sent    = 0;
    int          roots_checked = 0;
    int          quiet_cycles  = 0;

    decimal_fixed_point_square_root i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .radicand    (radicand),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .root_scaled (root_scaled)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // floor(sqrt(n * 100^p)), one root bit per step
    function automatic logic [ROOT_BITS-1:0] calc_root_scaled(
        logic [RADICAND_BITS-1:0] n, logic [FRAC_BITS-1:0] digits);
        logic [63:0] scaled;
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        int unsigned p;
        scaled = 64'(n);
        p = (digits > MAX_FRACTION_DIGITS) ? MAX_FRACTION_DIGITS : digits;
        repeat (p) scaled = scaled * 64'd100;
        rem   = scaled;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[ROOT_BITS-1:0];
    endfunction

    // random values, near perfect squares, small values and extremes
    function automatic logic [RADICAND_BITS-1:0] pick_radicand();
        int unsigned k;
        logic [RADICAND_BITS-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = RADICAND_BITS'($urandom);
            4, 5:
            begin
                k = $urandom_range(46340);
                v = RADICAND_BITS'(k * k + $urandom_range(2) - 1);
            end
            6: v = RADICAND_BITS'($urandom >> $urandom_range(31));
            7: v = RADICAND_BITS'($urandom_range(200));
            default: v = RADICAND_MAX - RADICAND_BITS'($urandom_range(3));
        endcase
        return v;
    endfunction

    function automatic void log_error(string msg);
        if (error_cnt < 10)
            $display("ERROR @%0t: %s", $time, msg);
        error_cnt++;
    endfunction

    // input side: one assignment per signal per edge
    always @(posedge clk or negedge rst_n)
    begin
        logic                     offering;
        logic                     next_valid;
        logic [RADICAND_BITS-1:0] next_radicand;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            radicand <= '0;
        end
        else
        begin
            offering      = in_valid;
            next_valid    = in_valid;
            next_radicand = radicand;
            if (in_valid && in_ready)
            begin
                expected_roots.push_back(calc_root_scaled(radicand, digits_cfg));
                items_sent++;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (pending_radicands.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    next_valid    = 1'b1;
                    next_radicand = pending_radicands.pop_front();
                end
                else
                begin
                    next_valid = 1'b0;
                end
            end
            in_valid <= next_valid;
            radicand <= next_radicand;
        end
    end

    // output side: check each transfer, then choose next ready
    always @(posedge clk or negedge rst_n)
    begin
        logic [ROOT_BITS-1:0] want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_roots.size() == 0)
                begin
                    log_error($sformatf("root %0d with nothing expected", root_scaled));
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (root_scaled !== want)
                        log_error($sformatf("root_scaled expected %0d got %0d",
                                            want, root_scaled));
                end
                roots_checked++;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (long_hold_req)
            begin
                // long stall so the block backs up into its input
                out_ready     <= 1'b0;
                hold_left     <= LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("FAIL decimal_fixed_point_square_root");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_radicands.size() != 0 || in_valid || expected_roots.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_digits(logic [FRAC_BITS-1:0] v);
        wait_drained();
        @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= v;
        digits_cfg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(logic [FRAC_BITS-1:0] digits, int unsigned idle,
                              int unsigned stall, int count, bit long_hold);
        write_digits(digits);
        idle_pct      = idle;
        stall_pct     = stall;
        long_hold_req = long_hold;
        repeat (count) pending_radicands.push_back(pick_radicand());
    endtask

    initial
    begin
        logic [RADICAND_BITS-1:0] directed[$];
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes and squares under the reset digit count
        directed = '{0, 1, 2, 3, 4, 15, 16, 99, 100, 10000,
                     2147395600, 2147395599, 2147395601,
                     RADICAND_MAX, RADICAND_MAX - 1, 31'h4000_0000, 31'h2AAA_AAAA,
                     31'h5555_5555, 31'h0000_FFFF, 31'h7FFF_0000};
        foreach (directed[i]) pending_radicands.push_back(directed[i]);

        run_random(2'd0, 0, 0, 100, 1'b0);
        run_random(2'd1, 49, 0, 100, 1'b0);
        run_random(2'd2, 0, 49, 100, 1'b0);
        run_random(2'd3, 17, 17, 100, 1'b0);
        run_random(2'd2, 0, 0, 30, 1'b1);
        run_random(2'd0, 17, 17, 100, 1'b0);
        run_random(2'd1, 0, 0, 100, 1'b0);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d radicands sent, %0d roots checked at 0 to 3 fraction digits,",
                 items_sent, roots_checked);
        $display("with sender gaps, receiver stalls and one long output hold");
        if (error_cnt == 0 && expected_roots.size() == 0)
        begin
            $display("PASS decimal_fixed_point_square_root");
        end
        else
        begin
            $display("%0d mismatches, %0d roots missing", error_cnt, expected_roots.size());
            $display("FAIL decimal_fixed_point_square_root");
        end
        $finish;
    end

endmodule

[decimal_fixed_point_square_root.f]
+incdir+rtl
rtl/dfsr_pkg.sv
rtl/dfsr_ctrl.sv
rtl/dfsr_datapath.sv
rtl/decimal_fixed_point_square_root.sv
tb/sv/tb_top.sv
